/* design/mlc_pkg.sv */
package mlc_pkg;

    // payload field types
    typedef logic signed [31:0] t_slope;
    typedef logic signed [47:0] t_icpt;
    typedef logic signed [31:0] t_point;
    typedef logic signed [63:0] t_value;
    typedef logic        [1:0]  t_status;

    // breakpoint, cross numerator and denominator
    typedef logic signed [49:0] t_bp;
    typedef logic signed [48:0] t_num;
    typedef logic        [31:0] t_den;

    // number of quotient bits the divider produces
    localparam int DivSteps = 49;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // one stored line
    typedef struct packed {
        t_bp    bp;
        t_icpt  icpt;
        t_slope slope;
    } t_entry;

    // divider request and response
    typedef struct packed {
        logic start;
        t_num numer;
        t_den denom;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_bp  quot;
    } t_div_rsp;

endpackage

/* design/mlc_if.sv */
interface mlc_in_if;
    logic            valid;
    logic            ready;
    logic            opcode;
    mlc_pkg::t_slope slope;
    mlc_pkg::t_icpt  intercept;
    mlc_pkg::t_point point;

    modport source  (output valid, opcode, slope, intercept, point, input ready);
    modport sink    (input valid, opcode, slope, intercept, point, output ready);
    modport monitor (input valid, opcode, slope, intercept, point, ready);
endinterface

interface mlc_out_if;
    logic             valid;
    logic             ready;
    mlc_pkg::t_value  value;
    mlc_pkg::t_status status;

    modport source  (output valid, value, status, input ready);
    modport sink    (input valid, value, status, output ready);
    modport monitor (input valid, value, status, ready);
endinterface

/* design/mlc_div.sv */
module mlc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mlc_pkg::t_div_req i_req,
    output mlc_pkg::t_div_rsp o_rsp
);
    import mlc_pkg::*;

    localparam int CntW = $clog2(DivSteps + 1);

    logic                r_busy;
    logic                r_done;
    logic [CntW-1:0]     r_cnt;
    logic [DivSteps-1:0] r_q;
    t_den                r_rem;
    t_den                r_den;
    logic                r_neg;

    logic [DivSteps-1:0] mag;
    logic [32:0]         rem_sh;
    logic [32:0]         rem_sub;
    logic                ge;
    logic [49:0]         q_ext;
    logic [49:0]         quot_u;

    // magnitude of the numerator, one restoring step
    always_comb begin
        mag     = i_req.numer[DivSteps-1] ? (~i_req.numer + 1'b1) : i_req.numer;
        rem_sh  = {r_rem, r_q[DivSteps-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    // round the quotient toward plus infinity
    always_comb begin
        q_ext  = {1'b0, r_q};
        quot_u = r_neg ? (~q_ext + 50'd1) : (q_ext + {49'd0, (r_rem != '0)});
        o_rsp.done = r_done;
        o_rsp.quot = t_bp'(quot_u);
    end

    // control: count the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(DivSteps);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift in one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= mag;
            r_rem <= '0;
            r_den <= i_req.denom;
            r_neg <= i_req.numer[DivSteps-1];
        end else if (r_busy) begin
            r_q   <= {r_q[DivSteps-2:0], ge};
            r_rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

endmodule

/* design/max_line_container_unit.sv */
// A query reads the table one entry per cycle, then multiplies and adds. An insert scans for
// its slot, shifts the table one entry per cycle, and runs neighbor checks, each of which may
// use the 49-step divider; each dropped line costs another shift. One item at a time.
// Reset (synchronous, active low) empties the table and clears control; the line memory
// itself is not cleared.
module max_line_container_unit #(
    parameter int MAX_LINES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mlc_in_if.sink    i_in,
    mlc_out_if.source o_out
);
    import mlc_pkg::*;

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam logic [CW-1:0] CntMax = CW'(MAX_LINES);
    localparam logic [CW-1:0] CntOne = CW'(1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_QSCAN  = 5'd1;
    localparam logic [4:0] S_QMUL   = 5'd2;
    localparam logic [4:0] S_QADD   = 5'd3;
    localparam logic [4:0] S_ISCAN  = 5'd4;
    localparam logic [4:0] S_IPLACE = 5'd5;
    localparam logic [4:0] S_SHIFT  = 5'd6;
    localparam logic [4:0] S_KLD    = 5'd7;
    localparam logic [4:0] S_KDA    = 5'd8;
    localparam logic [4:0] S_KWA    = 5'd9;
    localparam logic [4:0] S_KDB    = 5'd10;
    localparam logic [4:0] S_KWB    = 5'd11;
    localparam logic [4:0] S_KWR    = 5'd12;
    localparam logic [4:0] S_KWR2   = 5'd13;
    localparam logic [4:0] S_KRET   = 5'd14;
    localparam logic [4:0] S_LEFT   = 5'd15;
    localparam logic [4:0] S_RIGHT  = 5'd16;
    localparam logic [4:0] S_DONE   = 5'd17;

    localparam logic [1:0] KM_FIRST = 2'd0;
    localparam logic [1:0] KM_LAST  = 2'd1;
    localparam logic [1:0] KM_MID   = 2'd2;

    localparam logic [1:0] CTX_POS   = 2'd0;
    localparam logic [1:0] CTX_LEFT  = 2'd1;
    localparam logic [1:0] CTX_RIGHT = 2'd2;

    // control registers
    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_rv, n_rv;
    logic          r_ov, n_ov;

    // payload registers
    logic          r_op, n_op;
    t_slope        r_m, n_m;
    t_icpt         r_b, n_b;
    t_point        r_x, n_x;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_ridx, n_ridx;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_eq, n_eq;
    t_entry        r_best, n_best;
    t_entry        r_lo, n_lo;
    t_entry        r_mid, n_mid;
    t_entry        r_hi, n_hi;
    logic [CW-1:0] r_kidx, n_kidx;
    logic [1:0]    r_kmode, n_kmode;
    logic [1:0]    r_ctx, n_ctx;
    logic [1:0]    r_ksub, n_ksub;
    t_bp           r_bpa, n_bpa;
    t_bp           r_bpb, n_bpb;
    logic          r_kres, n_kres;
    logic          r_up, n_up;
    logic [4:0]    r_after, n_after;
    t_value        r_prod, n_prod;
    t_value        r_res_val, n_res_val;
    t_status       r_res_st, n_res_st;
    t_value        r_oval, n_oval;
    t_status       r_ost, n_ost;

    // line memory
    t_entry        r_mem [MAX_LINES];
    t_entry        r_rdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     issue;

    mlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // synchronous memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // ports
    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_ov;
    assign o_out.value  = r_oval;
    assign o_out.status = r_ost;

    assign issue = (r_idx < r_count);

    // sequencer
    always_comb begin
        n_state = r_state;  n_count = r_count;  n_rv = r_rv;  n_ov = r_ov;
        n_op = r_op;  n_m = r_m;  n_b = r_b;  n_x = r_x;
        n_idx = r_idx;  n_ridx = r_ridx;  n_left = r_left;  n_pos = r_pos;  n_eq = r_eq;
        n_best = r_best;  n_lo = r_lo;  n_mid = r_mid;  n_hi = r_hi;
        n_kidx = r_kidx;  n_kmode = r_kmode;  n_ctx = r_ctx;  n_ksub = r_ksub;
        n_bpa = r_bpa;  n_bpb = r_bpb;  n_kres = r_kres;  n_up = r_up;  n_after = r_after;
        n_prod = r_prod;  n_res_val = r_res_val;  n_res_st = r_res_st;
        n_oval = r_oval;  n_ost = r_ost;

        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_mid;

        div_req.start = 1'b0;
        div_req.numer = t_num'(r_lo.icpt) - t_num'(r_mid.icpt);
        div_req.denom = t_den'(r_mid.slope - r_lo.slope);

        // drain the output register
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op      = i_in.opcode;
                    n_m       = i_in.slope;
                    n_b       = i_in.intercept;
                    n_x       = i_in.point;
                    n_res_val = '0;
                    n_res_st  = ST_OK;
                    n_idx     = '0;
                    n_rv      = 1'b0;
                    if (i_in.opcode == OP_QUERY) begin
                        if (r_count == '0) begin
                            n_res_st = ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_QSCAN;
                        end
                    end else begin
                        n_state = S_ISCAN;
                    end
                end
            end

            // keep the last line whose breakpoint is not above the point
            S_QSCAN: begin
                if (issue) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[AW-1:0];
                    n_idx     = r_idx + CntOne;
                    n_ridx    = r_idx[AW-1:0];
                    n_rv      = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv && (r_ridx == '0 || r_rdata.bp <= t_bp'(r_x))) begin
                    n_best = r_rdata;
                end
                if (!issue && !r_rv) begin
                    n_state = S_QMUL;
                end
            end

            S_QMUL: begin
                n_prod  = t_value'(r_x * r_best.slope);
                n_state = S_QADD;
            end

            S_QADD: begin
                n_res_val = r_prod + t_value'(r_best.icpt);
                n_state   = S_DONE;
            end

            // find the first slope not below the new one
            S_ISCAN: begin
                if (issue) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[AW-1:0];
                    n_idx     = r_idx + CntOne;
                    n_ridx    = r_idx[AW-1:0];
                    n_rv      = 1'b1;
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv && r_rdata.slope >= r_m) begin
                    n_pos   = CW'(r_ridx);
                    n_mid   = r_rdata;
                    n_eq    = (r_rdata.slope == r_m);
                    n_state = S_IPLACE;
                end else if (!issue && !r_rv) begin
                    n_pos   = r_count;
                    n_eq    = 1'b0;
                    n_state = S_IPLACE;
                end
            end

            S_IPLACE: begin
                if (r_eq) begin
                    if (r_mid.icpt > r_b) begin
                        n_state = S_DONE;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_pos[AW-1:0];
                        mem_wdata = '{bp: r_mid.bp, icpt: r_b, slope: r_m};
                        n_kidx    = r_pos;
                        n_ctx     = CTX_POS;
                        n_ksub    = '0;
                        n_state   = S_KLD;
                    end
                end else if (r_count == CntMax) begin
                    n_res_st = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_up    = 1'b1;
                    n_idx   = r_count - CntOne;
                    n_left  = r_count - r_pos;
                    n_rv    = 1'b0;
                    n_state = S_SHIFT;
                end
            end

            // move a run of entries one place up or down
            S_SHIFT: begin
                if (r_left != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[AW-1:0];
                    n_ridx    = r_idx[AW-1:0];
                    n_rv      = 1'b1;
                    n_idx     = r_up ? (r_idx - CntOne) : (r_idx + CntOne);
                    n_left    = r_left - CntOne;
                end else begin
                    n_rv = 1'b0;
                end
                if (r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_up ? (r_ridx + 1'b1) : (r_ridx - 1'b1);
                    mem_wdata = r_rdata;
                end
                if (r_left == '0 && !r_rv) begin
                    if (r_up) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_pos[AW-1:0];
                        mem_wdata = '{bp: '0, icpt: r_b, slope: r_m};
                        n_count   = r_count + CntOne;
                        n_kidx    = r_pos;
                        n_ctx     = CTX_POS;
                        n_ksub    = '0;
                        n_state   = S_KLD;
                    end else begin
                        n_count = r_count - CntOne;
                        n_state = r_after;
                    end
                end
            end

            // load the entry and its two neighbors
            S_KLD: begin
                n_ksub = r_ksub + 1'b1;
                mem_re = 1'b1;
                case (r_ksub)
                    2'd0: mem_raddr = r_kidx[AW-1:0] - 1'b1;
                    2'd1: begin
                        mem_raddr = r_kidx[AW-1:0];
                        n_lo      = r_rdata;
                    end
                    2'd2: begin
                        mem_raddr = r_kidx[AW-1:0] + 1'b1;
                        n_mid     = r_rdata;
                    end
                    default: begin
                        mem_re = 1'b0;
                        n_hi   = r_rdata;
                        if (r_kidx == '0) begin
                            n_kmode = KM_FIRST;
                        end else if (r_kidx + CntOne >= r_count) begin
                            n_kmode = KM_LAST;
                        end else begin
                            n_kmode = KM_MID;
                        end
                        n_state = S_KDA;
                    end
                endcase
            end

            S_KDA: begin
                if (r_kmode == KM_FIRST && r_count <= CntOne) begin
                    n_kres  = 1'b1;
                    n_state = S_KRET;
                end else begin
                    div_req.start = 1'b1;
                    if (r_kmode == KM_FIRST) begin
                        div_req.numer = t_num'(r_mid.icpt) - t_num'(r_hi.icpt);
                        div_req.denom = t_den'(r_hi.slope - r_mid.slope);
                    end
                    n_state = S_KWA;
                end
            end

            S_KWA: begin
                if (div_rsp.done) begin
                    if (r_kmode == KM_FIRST) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_kidx[AW-1:0] + 1'b1;
                        mem_wdata = '{bp: div_rsp.quot, icpt: r_hi.icpt, slope: r_hi.slope};
                        n_kres    = 1'b1;
                        n_state   = S_KRET;
                    end else if (r_kmode == KM_LAST) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_kidx[AW-1:0];
                        mem_wdata = '{bp: div_rsp.quot, icpt: r_mid.icpt, slope: r_mid.slope};
                        n_kres    = 1'b1;
                        n_state   = S_KRET;
                    end else begin
                        n_bpa   = div_rsp.quot;
                        n_state = S_KDB;
                    end
                end
            end

            S_KDB: begin
                div_req.start = 1'b1;
                div_req.numer = t_num'(r_mid.icpt) - t_num'(r_hi.icpt);
                div_req.denom = t_den'(r_hi.slope - r_mid.slope);
                n_state       = S_KWB;
            end

            S_KWB: begin
                if (div_rsp.done) begin
                    n_bpb   = div_rsp.quot;
                    n_state = S_KWR;
                end
            end

            // drop the middle line when its breakpoints cross
            S_KWR: begin
                if (r_bpa > r_bpb) begin
                    n_kres  = 1'b0;
                    n_state = S_KRET;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_kidx[AW-1:0];
                    mem_wdata = '{bp: r_bpa, icpt: r_mid.icpt, slope: r_mid.slope};
                    n_state   = S_KWR2;
                end
            end

            S_KWR2: begin
                mem_we    = 1'b1;
                mem_waddr = r_kidx[AW-1:0] + 1'b1;
                mem_wdata = '{bp: r_bpb, icpt: r_hi.icpt, slope: r_hi.slope};
                n_kres    = 1'b1;
                n_state   = S_KRET;
            end

            // act on the check result by caller
            S_KRET: begin
                case (r_ctx)
                    CTX_POS: begin
                        if (r_kres) begin
                            n_state = S_LEFT;
                        end else begin
                            n_up    = 1'b0;
                            n_idx   = r_pos + CntOne;
                            n_left  = r_count - r_pos - CntOne;
                            n_rv    = 1'b0;
                            n_after = S_DONE;
                            n_state = S_SHIFT;
                        end
                    end
                    CTX_LEFT: begin
                        if (r_kres) begin
                            n_state = S_RIGHT;
                        end else begin
                            n_up    = 1'b0;
                            n_idx   = r_pos;
                            n_left  = r_count - r_pos;
                            n_rv    = 1'b0;
                            n_pos   = r_pos - CntOne;
                            n_after = S_LEFT;
                            n_state = S_SHIFT;
                        end
                    end
                    default: begin
                        if (r_kres) begin
                            n_state = S_DONE;
                        end else begin
                            n_up    = 1'b0;
                            n_idx   = r_pos + CW'(2);
                            n_left  = r_count - r_pos - CW'(2);
                            n_rv    = 1'b0;
                            n_after = S_RIGHT;
                            n_state = S_SHIFT;
                        end
                    end
                endcase
            end

            S_LEFT: begin
                if (r_pos != '0) begin
                    n_kidx  = r_pos - CntOne;
                    n_ctx   = CTX_LEFT;
                    n_ksub  = '0;
                    n_state = S_KLD;
                end else begin
                    n_state = S_RIGHT;
                end
            end

            S_RIGHT: begin
                if (r_pos + CntOne < r_count) begin
                    n_kidx  = r_pos + CntOne;
                    n_ctx   = CTX_RIGHT;
                    n_ksub  = '0;
                    n_state = S_KLD;
                end else begin
                    n_state = S_DONE;
                end
            end

            // hand the beat to the output register
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov    = 1'b1;
                    n_oval  = r_res_val;
                    n_ost   = r_res_st;
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rv    <= n_rv;
            r_ov    <= n_ov;
        end
    end

    // payload state
    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_m <= n_m;  r_b <= n_b;  r_x <= n_x;
        r_idx <= n_idx;  r_ridx <= n_ridx;  r_left <= n_left;  r_pos <= n_pos;  r_eq <= n_eq;
        r_best <= n_best;  r_lo <= n_lo;  r_mid <= n_mid;  r_hi <= n_hi;
        r_kidx <= n_kidx;  r_kmode <= n_kmode;  r_ctx <= n_ctx;  r_ksub <= n_ksub;
        r_bpa <= n_bpa;  r_bpb <= n_bpb;  r_kres <= n_kres;  r_up <= n_up;
        r_after <= n_after;  r_prod <= n_prod;
        r_res_val <= n_res_val;  r_res_st <= n_res_st;
        r_oval <= n_oval;  r_ost <= n_ost;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntMax)
        else $error("line count above table size");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_st == ST_FULL) |-> (r_count == CntMax))
        else $error("full status with free entries");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_op == OP_QUERY && r_res_st == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with lines stored");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_KWA || r_state == S_KWB))
        else $error("divider result outside a wait state");

    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (CW'(mem_waddr) <= r_count))
        else $error("write beyond the filled table");

endmodule

/* test/mlc_check.sv */
`timescale 1ns / 100ps

module mlc_check #(
    parameter int MAX_LINES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mlc_in_if.monitor  i_in,
    mlc_out_if.monitor i_out,
    output int         o_errors,
    output int         o_pending
);
    import mlc_pkg::*;

    typedef struct {
        t_value  value;
        t_status status;
    } t_answer;

    // envelope copy, kept at wide widths
    longint env_slope[MAX_LINES];
    longint env_icpt[MAX_LINES];
    longint env_bp[MAX_LINES];
    int     env_count;
    t_answer answers[$];
    int     n_err;

    assign o_errors  = n_err;
    assign o_pending = answers.size();

    function automatic longint ceil_quot(longint n, longint d);
        if (d == 0) return 0;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (n >= 0) return (n + d - 1) / d;
        return -((-n) / d);
    endfunction

    // breakpoint of line a against line q
    function automatic longint meet(int a, int q);
        return ceil_quot(env_icpt[q] - env_icpt[a], env_slope[a] - env_slope[q]);
    endfunction

    function automatic void drop_line(int i);
        for (int k = i; k < env_count - 1; k++) begin
            env_slope[k] = env_slope[k+1];
            env_icpt[k]  = env_icpt[k+1];
            env_bp[k]    = env_bp[k+1];
        end
        env_count--;
    endfunction

    // check line i still reaches the envelope, refresh breakpoints
    function automatic bit reaches(int i);
        longint lo, hi;
        if (i == 0) begin
            if (env_count > 1) env_bp[1] = meet(1, 0);
            env_bp[0] = 64'sh8000_0000_0000_0000;
            return 1;
        end
        if (i + 1 >= env_count) begin
            env_bp[i] = meet(i, i - 1);
            return 1;
        end
        lo = meet(i, i - 1);
        hi = meet(i, i + 1);
        if (lo > hi) return 0;
        env_bp[i]   = lo;
        env_bp[i+1] = hi;
        return 1;
    endfunction

    function automatic t_answer apply_beat(logic op, t_slope s, t_icpt b, t_point x);
        t_answer r;
        int pos;
        longint m, c, px;
        r.value  = '0;
        r.status = ST_OK;
        if (op == OP_QUERY) begin
            px = x;
            if (env_count == 0) begin
                r.status = ST_EMPTY;
                return r;
            end
            pos = 0;
            for (int i = 1; i < env_count; i++)
                if (env_bp[i] <= px) pos = i;
            r.value = px * env_slope[pos] + env_icpt[pos];
            return r;
        end
        m = s;
        c = b;
        pos = 0;
        while (pos < env_count && env_slope[pos] < m) pos++;
        if (pos < env_count && env_slope[pos] == m) begin
            if (env_icpt[pos] > c) return r;
            env_icpt[pos] = c;
        end else begin
            if (env_count >= MAX_LINES) begin
                r.status = ST_FULL;
                return r;
            end
            for (int k = env_count; k > pos; k--) begin
                env_slope[k] = env_slope[k-1];
                env_icpt[k]  = env_icpt[k-1];
                env_bp[k]    = env_bp[k-1];
            end
            env_slope[pos] = m;
            env_icpt[pos]  = c;
            env_bp[pos]    = 64'sh8000_0000_0000_0000;
            env_count++;
        end
        if (!reaches(pos)) begin
            drop_line(pos);
            return r;
        end
        while (pos > 0) begin
            if (reaches(pos - 1)) break;
            drop_line(pos - 1);
            pos--;
            if (pos == 0) begin
                env_bp[0] = 64'sh8000_0000_0000_0000;
                break;
            end
        end
        while (pos + 1 < env_count && !reaches(pos + 1)) drop_line(pos + 1);
        return r;
    endfunction

    task automatic report(string what);
        n_err++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // predict on each input beat, compare on each output beat
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            env_count = 0;
            n_err     = 0;
            answers.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                answers.push_back(apply_beat(i_in.opcode, i_in.slope,
                                             i_in.intercept, i_in.point));
            if (i_out.valid && i_out.ready) begin
                if (answers.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = answers.pop_front();
                    if (i_out.value !== want.value)
                        report($sformatf("value %0d, expected %0d",
                                         i_out.value, want.value));
                    if (i_out.status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         i_out.status, want.status));
                end
            end
        end
    end
endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import mlc_pkg::*;

    localparam int Lines = 256;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   send_idle = 0;
    int   recv_stall = 0;
    int   n_err;
    int   n_pending;

    mlc_in_if  in_ch ();
    mlc_out_if out_ch ();

    max_line_container_unit #(.MAX_LINES(Lines)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    mlc_check #(.MAX_LINES(Lines)) checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.monitor), .i_out(out_ch.monitor),
        .o_errors(n_err), .o_pending(n_pending)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid     = 0;
        in_ch.opcode    = OP_INSERT;
        in_ch.slope     = '0;
        in_ch.intercept = '0;
        in_ch.point     = '0;
        out_ch.ready    = 0;
    end

    // receiver stalls at random
    always @(posedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall);

    // send one beat, idling first at random; valid stays high into the next beat
    task automatic send(logic op, t_slope s, t_icpt b, t_point x);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1;
        in_ch.opcode    <= op;
        in_ch.slope     <= s;
        in_ch.intercept <= b;
        in_ch.point     <= x;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic t_slope pick_slope(int mode);
        case (mode)
            0: return $signed($urandom_range(40)) - 20;
            1: return $urandom;
            default: return $signed($urandom_range(4000)) - 2000;
        endcase
    endfunction

    function automatic t_icpt pick_icpt(int mode);
        case (mode)
            0: return t_icpt'($signed($urandom_range(200)) - 100);
            1: return t_icpt'({$urandom, $urandom});
            default: return t_icpt'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    initial begin
        int mode;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty query, extremes, equal slopes, ties
        send(OP_QUERY, 0, 0, 5);
        send(OP_INSERT, 32'sh7fff_ffff, 48'sh7fff_ffff_ffff, 0);
        send(OP_INSERT, 32'sh8000_0000, 48'sh8000_0000_0000, 0);
        send(OP_QUERY, 0, 0, 32'sh7fff_ffff);
        send(OP_QUERY, 0, 0, 32'sh8000_0000);
        send(OP_INSERT, 0, 0, 0);
        send(OP_INSERT, 0, -5, 0);
        send(OP_INSERT, 0, 7, 0);
        send(OP_INSERT, 1, 0, 0);
        send(OP_INSERT, -1, 0, 0);
        send(OP_INSERT, 2, -1, 0);
        send(OP_QUERY, 0, 0, 0);
        send(OP_QUERY, 0, 0, -1);
        send(OP_QUERY, 0, 0, 1);
        send(OP_INSERT, 5, 48'sh7fff_ffff_ffff, 0);
        send(OP_QUERY, 0, 0, 32'shffff_ffff);

        // random phases; the table is refilled to full in the middle
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 58; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 58; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            for (int n = 0; n < 460; n++) begin
                mode = $urandom_range(2);
                if (ph == 2 && n < 300)
                    // parabola-like lines all stay on the envelope: fills table
                    send(OP_INSERT, n - 150, t_icpt'(-((n - 150) * (n - 150))), 0);
                else if ($urandom_range(1))
                    send(OP_QUERY, 0, 0, $urandom_range(3) == 0 ?
                         $urandom : $signed($urandom_range(400)) - 200);
                else
                    send(OP_INSERT, pick_slope(mode), pick_icpt(mode), 0);
            end
        end

        in_ch.valid <= 0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (n_err == 0 && n_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #400ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
